// ===== rtl/csrmv_pkg.sv =====
// Package for the CSR sparse matrix-vector multiply block.
// Holds the action codes, the item structs of both channels and the
// stage struct that carries a product into the accumulator. No dependencies.
`default_nettype none

package csrmv_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_NONZERO = 2'd1,
    ACT_EMPTY   = 2'd2,
    ACT_START   = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [11:0]        index;
    logic signed [31:0] value;
    logic               row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] row_sum;
    logic [15:0]        row_number;
    logic               saturated;
    logic               bad_index;
  } out_item_t;

  // One item on its way from the multiplier stage to the accumulator.
  typedef struct packed {
    logic               valid;
    action_t            action;
    logic               row_end;
    logic               in_range;
    logic signed [63:0] product;
  } mac_op_t;

endpackage

`default_nettype wire

// ===== rtl/csrmv_x_store.sv =====
// Synchronous x vector store: one write port, one read port, registered read.
// Depends on nothing but its parameters.
`default_nettype none

module csrmv_x_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic signed [31:0]   wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic signed [31:0]        rdata
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read data while the pipeline is frozen.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/csrmv_accum.sv =====
// Row accumulator with saturating add, row counter and result register.
// Depends on csrmv_pkg for mac_op_t, out_item_t and the action codes.
`default_nettype none

module csrmv_accum
  import csrmv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire mac_op_t   mac,
  output logic           out_valid,
  output out_item_t      out_item
);

  logic signed [63:0] acc_r, acc_nxt, acc_upd, sum, clamp;
  logic [15:0]        cnt_r, cnt_nxt;
  logic               sat_r, sat_nxt, sat_upd;
  logic               bad_r, bad_nxt, bad_upd;
  logic               ovf, emit;
  logic               out_valid_r;
  out_item_t          out_item_r, out_nxt;

  assign sum   = acc_r + mac.product;
  assign ovf   = (acc_r[63] == mac.product[63]) && (sum[63] != acc_r[63]);
  assign clamp = acc_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};

  always_comb begin
    acc_upd = acc_r;
    sat_upd = sat_r;
    bad_upd = bad_r;
    cnt_nxt = cnt_r;
    emit    = 1'b0;
    if (mac.valid) begin
      unique case (mac.action)
        ACT_NONZERO: begin
          if (mac.in_range) begin
            acc_upd = ovf ? clamp : sum;
            sat_upd = sat_r | ovf;
          end else begin
            bad_upd = 1'b1;
          end
          emit = mac.row_end;
        end
        ACT_EMPTY: begin
          emit = 1'b1;
        end
        ACT_START: begin
          acc_upd = '0;
          sat_upd = 1'b0;
          bad_upd = 1'b0;
          cnt_nxt = '0;
        end
        ACT_LOAD: begin
        end
      endcase
    end
    out_nxt = '{row_sum: acc_upd, row_number: cnt_r, saturated: sat_upd,
                bad_index: bad_upd};
    if (emit) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
      bad_nxt = 1'b0;
      cnt_nxt = cnt_r + 16'd1;
    end else begin
      acc_nxt = acc_upd;
      sat_nxt = sat_upd;
      bad_nxt = bad_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en && emit) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_reset_clears_out : assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_frozen_counter : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cnt_r) && $stable(acc_r))
    else $error("row state moved while frozen");

  a_emit_advances : assert property (@(posedge clk) disable iff (!rst_n)
    (en && emit) |=> (cnt_r == 16'($past(cnt_r) + 16'd1)) && (acc_r == '0))
    else $error("row counter did not advance on result");

endmodule

`default_nettype wire

// ===== rtl/csr_sparse_matrix_vector_multiply.sv =====
// Top level of the CSR sparse matrix-vector multiply block.
// Depends on csrmv_pkg, csrmv_x_store and csrmv_accum.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one item per cycle
//   while in_stall is low: load an x entry, a matrix nonzero (column, value,
//   row_end), an empty row marker, or a start of a new product. Load x entries
//   before any nonzero that reads them. cfg_write_en / cfg_write_data set
//   col_base, which is added to each nonzero's column before the x store is
//   read; write it only while the block is idle.
//   Result channel (out_valid / out_stall / out_item) carries one item per
//   finished row: Q16.48 sum, row number, saturation and bad-index flags.
// Timing:
//   Three stages: x store read, 32x32 multiply, saturating accumulate into
//   the result register. A row's result lands there once its last item has
//   passed the read and multiply stages. One item is accepted every cycle
//   unless stalled; the accumulate loop in the last stage sets that rate.
// Reset (rst_n, synchronous): clears the pipeline, accumulator, flags, row
//   counter and col_base. The x store is not cleared.
// Stall: while a result waits under out_stall the whole pipeline freezes and
//   in_stall is raised; it drops in the cycle the result is taken.
`default_nettype none

module csr_sparse_matrix_vector_multiply
  import csrmv_pkg::*;
#(
  parameter int X_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic [11:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item
);

  localparam int AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam logic [16:0] DEPTH_L = 17'(X_DEPTH);

  logic [11:0]        col_base_r;
  logic               en, in_acc;
  logic [16:0]        rd_addr, ld_addr;
  logic               rd_ok, ld_ok, x_we;
  logic signed [31:0] x_rdata;

  // Read stage registers.
  logic               s1_valid_r;
  action_t            s1_action_r;
  logic               s1_row_end_r;
  logic               s1_ok_r;
  logic signed [31:0] s1_value_r;

  // Multiply stage.
  logic signed [63:0] prod;
  mac_op_t            mac_r, mac_nxt;

  // Advance everything unless a result waits under stall.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_base_r <= '0;
    end else if (cfg_write_en) begin
      col_base_r <= cfg_write_data;
    end
  end

  // Column plus base; flag anything past the store.
  assign rd_addr = 17'(in_item.index) + 17'(col_base_r);
  assign ld_addr = 17'(in_item.index);
  assign rd_ok   = rd_addr < DEPTH_L;
  assign ld_ok   = ld_addr < DEPTH_L;
  // Drop loads that fall outside the store.
  assign x_we    = in_acc && (in_item.action == ACT_LOAD) && ld_ok;

  csrmv_x_store #(
    .DEPTH (X_DEPTH),
    .AW    (AW)
  ) u_x_store (
    .clk   (clk),
    .we    (x_we),
    .waddr (ld_addr[AW-1:0]),
    .wdata (in_item.value),
    .re    (en),
    .raddr (rd_addr[AW-1:0]),
    .rdata (x_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_action_r  <= in_item.action;
      s1_row_end_r <= in_item.row_end;
      s1_ok_r      <= rd_ok;
      s1_value_r   <= in_item.value;
    end
  end

  // Q8.24 times Q8.24 is exact in Q16.48; zero it for anything but an
  // in-range nonzero so the x data of other items never matters.
  assign prod = $signed(s1_value_r) * $signed(x_rdata);

  always_comb begin
    mac_nxt.valid    = s1_valid_r;
    mac_nxt.action   = s1_action_r;
    mac_nxt.row_end  = s1_row_end_r;
    mac_nxt.in_range = s1_ok_r;
    mac_nxt.product  = (s1_ok_r && (s1_action_r == ACT_NONZERO)) ? prod : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r.valid <= 1'b0;
    end else if (en) begin
      mac_r <= mac_nxt;
    end
  end

  csrmv_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mac       (mac_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== bench/csr_sparse_matrix_vector_multiply_tb.sv =====
// Self-checking bench for the CSR sparse matrix-vector multiply block.
// Needs csrmv_pkg and the block's RTL; stimulus and expected rows are made here.

module csr_sparse_matrix_vector_multiply_tb
  import csrmv_pkg::*;
();

  localparam int X_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 400000;
  // Pipeline is three stages deep; give items that emit nothing room to land.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 260;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] SUM_MAX = 64'sh7fff_ffff_ffff_ffff;

  // Mirror of the block: x store, row accumulator and flags, plus the queue of
  // row results that are owed by the block but not yet seen.
  class row_sum_tracker;
    logic signed [31:0] x_mem [X_DEPTH];
    bit                 x_loaded [X_DEPTH];
    logic signed [63:0] row_acc = '0;
    logic [15:0]        row_count = '0;
    logic               row_sat = 1'b0;
    logic               row_bad = 1'b0;
    logic [11:0]        col_base = '0;
    out_item_t          pending_rows [$];
    int unsigned        mismatches = 0;

    function void close_row();
      out_item_t done;
      done.row_sum    = row_acc;
      done.row_number = row_count;
      done.saturated  = row_sat;
      done.bad_index  = row_bad;
      pending_rows = {pending_rows, done};
      row_acc   = '0;
      row_sat   = 1'b0;
      row_bad   = 1'b0;
      row_count = row_count + 16'd1;
    endfunction

    // Update the mirror with one accepted input item.
    function void take_item(in_item_t it);
      int unsigned        addr;
      logic signed [63:0] lhs, rhs, prod, sum;
      case (it.action)
        ACT_LOAD: begin
          if (it.index < X_DEPTH) begin
            x_mem[it.index]    = it.value;
            x_loaded[it.index] = 1'b1;
          end
        end
        ACT_NONZERO: begin
          addr = it.index;
          addr = addr + col_base;
          if (addr < X_DEPTH) begin
            lhs  = it.value;
            rhs  = x_mem[addr];
            prod = lhs * rhs;
            sum  = row_acc + prod;
            // Clamp when both addends share a sign the sum lost.
            if (row_acc[63] == prod[63] && sum[63] != row_acc[63]) begin
              row_sat = 1'b1;
              sum     = row_acc[63] ? SUM_MIN : SUM_MAX;
            end
            row_acc = sum;
          end else begin
            row_bad = 1'b1;
          end
          if (it.row_end) close_row();
        end
        ACT_EMPTY: close_row();
        default: begin
          row_acc   = '0;
          row_sat   = 1'b0;
          row_bad   = 1'b0;
          row_count = '0;
        end
      endcase
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result with the oldest owed row.
    function void check_row(out_item_t got);
      out_item_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row: expected none, actual sum %0h row %0d",
                 $time, got.row_sum, got.row_number);
        mismatches++;
        return;
      end
      want = pending_rows.pop_front();
      check_field("row_sum", want.row_sum, got.row_sum);
      check_field("row_number", 64'(want.row_number), 64'(got.row_number));
      check_field("saturated", 64'(want.saturated), 64'(got.saturated));
      check_field("bad_index", 64'(want.bad_index), 64'(got.bad_index));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_write_en;
  logic [11:0] cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  row_sum_tracker tracker = new();
  int unsigned    items_sent = 0;
  // Remaining items (or results) that go through without any idle cycles.
  int             send_calm = 0;
  int             stall_calm = 0;

  csr_sparse_matrix_vector_multiply #(.X_DEPTH(X_DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Q8.24 value biased toward the extremes so that saturation shows up.
  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return $signed(32'($urandom_range(0, 1023)) - 32'd512);
      default: return $signed($urandom());
    endcase
  endfunction

  // Mostly a narrow window of columns so x entries get reused; sometimes any.
  function automatic logic [11:0] pick_column();
    if ($urandom_range(0, 3) == 0) return 12'($urandom_range(0, X_DEPTH - 1));
    return 12'($urandom_range(0, 63));
  endfunction

  // Present one item, hold it until accepted, then note it. Returns on a
  // falling edge with in_valid still high.
  task automatic send_item(in_item_t it);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 29) == 0) send_calm = 40;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_load(logic [11:0] idx, logic signed [31:0] val);
    in_item_t it;
    it.action  = ACT_LOAD;
    it.index   = idx;
    it.value   = val;
    it.row_end = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Empty-row and start markers carry random filler in the unused fields.
  task automatic put_marker(action_t act);
    in_item_t it;
    it.action  = act;
    it.index   = 12'($urandom_range(0, X_DEPTH - 1));
    it.value   = $signed($urandom());
    it.row_end = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Load the addressed x entry first if it was never written.
  task automatic put_nonzero(logic [11:0] col, logic signed [31:0] val, logic last);
    in_item_t    it;
    int unsigned addr;
    addr = col;
    addr = addr + tracker.col_base;
    if (addr < X_DEPTH && !tracker.x_loaded[addr]) put_load(12'(addr), rand_fixed());
    it.action  = ACT_NONZERO;
    it.index   = col;
    it.value   = val;
    it.row_end = last;
    send_item(it);
  endtask

  // Send len nonzeros; the last one carries row_end = last.
  task automatic put_row(int len, logic last);
    for (int k = 0; k < len; k++)
      put_nonzero(pick_column(), rand_fixed(), (k == len - 1) ? last : 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_rows.size() != 0) @(negedge clk);
  endtask

  task automatic write_col_base(logic [11:0] base);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= base;
    @(negedge clk);
    cfg_write_en    <= 1'b0;
    tracker.col_base = base;
  endtask

  // Extremes of values and columns, each action, and the special rows:
  // empty row, saturation both ways, a row closed by an empty-row marker and
  // a row dropped by a start marker. Runs with col_base at its reset value.
  task automatic run_directed();
    put_load(12'd0, Q_MAX);
    put_load(12'd4095, Q_MIN);
    put_load(12'd1, -32'sd1);
    put_marker(ACT_EMPTY);
    put_nonzero(12'd4095, Q_MIN, 1'b1);
    put_nonzero(12'd0, Q_MAX, 1'b0);
    put_nonzero(12'd1, Q_MIN, 1'b0);
    put_nonzero(12'd4095, Q_MAX, 1'b1);
    // Five times 2^62 overflows upward.
    for (int k = 0; k < 5; k++) put_nonzero(12'd4095, Q_MIN, (k == 4));
    // Four large negative products overflow downward.
    for (int k = 0; k < 4; k++) put_nonzero(12'd4095, Q_MAX, (k == 3));
    put_nonzero(12'd0, 32'sd1, 1'b0);
    put_marker(ACT_EMPTY);
    put_nonzero(12'd0, 32'sd12345, 1'b0);
    put_marker(ACT_START);
    put_marker(ACT_EMPTY);
  endtask

  // Mostly well-formed rows with random content; some broken rows and noise.
  task automatic random_phase(int unsigned quota);
    int unsigned        stop_at;
    int                 style, len;
    logic [11:0]        col;
    int unsigned        addr;
    logic signed [31:0] main_val, flip_val;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      style = $urandom_range(0, 19);
      if (style == 0) begin
        // Hold off the sender until every owed row is out.
        drain_results();
      end else if (style <= 2) begin
        put_marker(ACT_EMPTY);
      end else if (style == 3) begin
        put_row($urandom_range(0, 4), 1'b0);
        put_marker(ACT_START);
      end else if (style <= 5) begin
        // Heavy row: one extreme x entry, many extreme products.
        col  = 12'($urandom_range(0, 63));
        addr = col;
        addr = addr + tracker.col_base;
        if (addr < X_DEPTH) put_load(12'(addr), Q_MIN);
        main_val = $urandom_range(0, 1) ? Q_MIN : Q_MAX;
        flip_val = (main_val == Q_MIN) ? Q_MAX : Q_MIN;
        len = $urandom_range(3, 9);
        for (int k = 0; k < len; k++)
          put_nonzero(col, (k == len - 2 && $urandom_range(0, 1)) ? flip_val : main_val,
                      (k == len - 1));
      end else if (style == 6) begin
        put_row($urandom_range(1, 4), 1'b0);
        put_marker(ACT_EMPTY);
      end else if (style == 7) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          put_load(12'($urandom_range(0, X_DEPTH - 1)), rand_fixed());
      end else begin
        put_row($urandom_range(1, 8), 1'b1);
      end
    end
  endtask

  // Result side: draw a stall length per result, then take the next one.
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (stall_calm > 0) begin
        stall_calm--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 10);
        if ($urandom_range(0, 29) == 0) stall_calm = 40;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_row(out_item);
      @(negedge clk);
    end
  end

  // Count cycles; stop a hung run.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [11:0] bases [7];
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    in_item        = '0;
    bases = '{12'd0, 12'd4095, 12'd0, 12'd2048, 12'd0, 12'd1, 12'd0};
    bases[2] = 12'($urandom_range(1, 4094));
    bases[4] = 12'($urandom_range(1, 4094));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    // Change col_base only once the pipeline has fully drained.
    foreach (bases[p]) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_col_base(bases[p]);
      random_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/csrmv_pkg.sv
rtl/csrmv_x_store.sv
rtl/csrmv_accum.sv
rtl/csr_sparse_matrix_vector_multiply.sv
bench/csr_sparse_matrix_vector_multiply_tb.sv
